[hdl/ldrl_pkg.sv]
package ldrl_pkg;

    localparam int LOG_FRAC   = 16;
    localparam int MANT_FRAC  = 30;
    localparam int PCT_FULL   = 100;
    localparam int PCT_W      = 7;
    localparam int TOP_W      = 8;
    localparam int SPAN_W     = 9;
    localparam int LVL_W      = 10;
    localparam int BASE_MIN_W = 21;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_BPS    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_TOP_LEVEL  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SPAN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_PCT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_PCT    = 8'd3;

    localparam logic signed [LVL_W-1:0] LVL_MAX = 10'sd511;
    localparam logic signed [LVL_W-1:0] LVL_MIN = -10'sd512;

    typedef struct packed {
        logic v;
        logic fault;
        logic d_zero;
        logic d_gt;
        logic q_zero;
        logic q_gt;
        logic den_ok;
    } t_flags;

endpackage

[hdl/ldrl_if.sv]
interface ldrl_in_if #(parameter int DW = 24);
    logic          valid;
    logic          ready;
    logic [DW-1:0] distance;
    logic [DW-1:0] max_distance;
    modport source (output valid, output distance, output max_distance, input ready);
    modport sink (input valid, input distance, input max_distance, output ready);
endinterface

interface ldrl_out_if import ldrl_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [LVL_W-1:0] signal_level;
    logic signed [LVL_W-1:0] link_quality;
    logic                    range_fault;
    modport source (output valid, output signal_level, output link_quality,
                    output range_fault, input ready);
    modport sink (input valid, input signal_level, input link_quality,
                  input range_fault, output ready);
endinterface

interface ldrl_cfg_if import ldrl_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/log_distance_rssi_lqi.sv]
// From input word to result word at default parameters: window reciprocal multiply,
// 18-stage log2, level divide retiring 4 bits a stage.
// Throughput: one word per cycle; the whole pipe holds only while the output
// register is full and not taken.
// Reset: synchronous active-low; clears valid bits and loads register defaults
// (top -30, span 60, near 0, far 0).
module log_distance_rssi_lqi import ldrl_pkg::*; #(
    parameter int DIST_WIDTH = 24,
    parameter int FRAC_BITS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ldrl_cfg_if.sink    i_cfg,
    ldrl_in_if.sink     i_in,
    ldrl_out_if.source  o_out
);

    localparam int DW   = DIST_WIDTH;
    localparam int PRW  = DW + PCT_W;
    localparam int RS   = PRW + 7;
    localparam int RW   = PRW + 1;
    localparam int PPW  = PRW + RW;
    localparam int KW   = $clog2(DW);
    localparam int LGW  = KW + LOG_FRAC;
    localparam int NW   = ((LGW > BASE_MIN_W) ? LGW : BASE_MIN_W) + 1;
    localparam int AW   = NW + 10;
    localparam int MW   = AW - 1;
    localparam int DENW = NW - 1;
    localparam logic signed [NW-1:0] BASE = NW'(FRAC_BITS * (2 ** LOG_FRAC));
    localparam logic [DW-1:0] ONE_FX = DW'(2 ** FRAC_BITS);
    localparam logic [RW-1:0] RECIP = RW'(((64'd1 << RS) / PCT_FULL) + 64'd1);

    typedef struct packed {
        logic          v;
        logic [DW-1:0] d;
        logic [DW-1:0] mx;
        logic          fault;
    } t_wtag;

    typedef struct packed {
        t_flags f;
        logic   negd;
        logic   negq;
    } t_stag;

    logic signed [TOP_W-1:0]  r_top;
    logic signed [SPAN_W-1:0] r_span;
    logic [PCT_W-1:0]         r_near;
    logic [PCT_W-1:0]         r_far;
    logic [PCT_W-1:0]         w_nearp;
    logic [PCT_W-1:0]         w_farp;

    logic                     en;

    logic                     r1_v;
    logic [DW-1:0]            r1_d;
    logic [DW-1:0]            r1_mx;

    t_wtag                    r2_tag;
    logic [PRW-1:0]           r2_pn;
    logic [PRW-1:0]           r2_pf;

    logic [PPW-1:0]           w_pn;
    logic [PPW-1:0]           w_pf;
    t_wtag                    r_wtag;
    logic [DW-1:0]            r_qn;
    logic [DW-1:0]            r_qf;
    logic [DW-1:0]            w_low;
    logic [DW-1:0]            w_up;
    logic [DW-1:0]            n3_q;

    t_flags                   r3_f;
    logic [DW-1:0]            r3_d;
    logic [DW-1:0]            r3_q;
    logic [DW-1:0]            r3_mx;

    logic [LGW-1:0]           w_lg_d;
    logic [LGW-1:0]           w_lg_q;
    logic [LGW-1:0]           w_lg_m;
    t_flags                   w_lf;
    logic                     w_lqv;
    logic                     w_lmv;

    t_flags                   r4_f;
    logic signed [NW-1:0]     r4_nd;
    logic signed [NW-1:0]     r4_nq;
    logic signed [NW-1:0]     r4_den;

    t_flags                   r5_f;
    logic signed [AW-1:0]     r5_td;
    logic signed [AW-1:0]     r5_sd;
    logic signed [AW-1:0]     r5_sq;
    logic signed [NW-1:0]     r5_den;

    logic signed [AW-1:0]     w_ad;
    logic signed [AW-1:0]     w_aq;
    t_stag                    r6_tag;
    logic [MW-1:0]            r6_magd;
    logic [MW-1:0]            r6_magq;
    logic [DENW-1:0]          r6_den;

    logic [MW-1:0]            w_quod;
    logic [MW-1:0]            w_quoq;
    t_stag                    w_stag;
    logic                     w_sqv;

    logic                     r_ov;
    logic signed [LVL_W-1:0]  r_lvl;
    logic signed [LVL_W-1:0]  r_lqi;
    logic                     r_fault;

    function automatic logic signed [LVL_W-1:0] f_level(
        logic          zero,
        logic          gt,
        logic          fault,
        logic          den_ok,
        logic          neg,
        logic [MW-1:0] mag,
        logic signed [TOP_W-1:0]  top,
        logic signed [SPAN_W-1:0] span
    );
        logic signed [LVL_W-1:0] res;
        if (zero) begin
            res = LVL_W'(top);
        end else if (gt || fault || !den_ok) begin
            res = LVL_W'(span);
        end else if (neg) begin
            res = (mag >= MW'(512)) ? LVL_MIN : -$signed(mag[LVL_W-1:0]);
        end else begin
            res = (mag > MW'(511)) ? LVL_MAX : $signed(mag[LVL_W-1:0]);
        end
        return res;
    endfunction

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top  <= -8'sd30;
            r_span <= 9'sd60;
            r_near <= '0;
            r_far  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TOP_LEVEL:  r_top  <= $signed(i_cfg.data[TOP_W-1:0]);
                REG_LEVEL_SPAN: r_span <= $signed(i_cfg.data[SPAN_W-1:0]);
                REG_NEAR_PCT:   r_near <= i_cfg.data[PCT_W-1:0];
                REG_FAR_PCT:    r_far  <= i_cfg.data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_nearp = (r_near > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : r_near;
    assign w_farp  = (r_far > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : r_far;

    assign en         = !r_ov || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v     <= 1'b0;
            r2_tag.v <= 1'b0;
        end else if (en) begin
            r1_v     <= i_in.valid;
            r2_tag.v <= r1_v;
        end
        if (en) begin
            r1_d         <= i_in.distance;
            r1_mx        <= i_in.max_distance;
            r2_tag.d     <= r1_d;
            r2_tag.mx    <= r1_mx;
            r2_tag.fault <= r1_mx <= ONE_FX;
            r2_pn        <= PRW'(r1_mx) * PRW'(w_nearp);
            r2_pf        <= PRW'(r1_mx) * PRW'(w_farp);
        end
    end

    assign w_pn = PPW'(r2_pn) * PPW'(RECIP);
    assign w_pf = PPW'(r2_pf) * PPW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wtag.v <= 1'b0;
        end else if (en) begin
            r_wtag.v <= r2_tag.v;
        end
        if (en) begin
            r_wtag.d     <= r2_tag.d;
            r_wtag.mx    <= r2_tag.mx;
            r_wtag.fault <= r2_tag.fault;
            r_qn         <= w_pn[RS +: DW];
            r_qf         <= w_pf[RS +: DW];
        end
    end

    assign w_low = r_qn;
    assign w_up  = r_wtag.mx - r_qf;

    always_comb begin
        priority if (w_low != '0 && r_wtag.d < w_low) begin
            n3_q = w_low;
        end else if (w_up != '0 && r_wtag.d > w_up) begin
            n3_q = w_up;
        end else begin
            n3_q = r_wtag.d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_f.v <= 1'b0;
        end else if (en) begin
            r3_f.v <= r_wtag.v;
        end
        if (en) begin
            r3_f.fault  <= r_wtag.fault;
            r3_f.d_zero <= r_wtag.d == '0;
            r3_f.d_gt   <= r_wtag.d > r_wtag.mx;
            r3_f.q_zero <= n3_q == '0;
            r3_f.q_gt   <= n3_q > r_wtag.mx;
            r3_f.den_ok <= 1'b0;
            r3_d        <= r_wtag.d;
            r3_q        <= n3_q;
            r3_mx       <= r_wtag.mx;
        end
    end

    ldrl_log2 #(.DW(DW), .TAG_W($bits(t_flags))) u_log_d (
        .i_clk, .i_rst_n, .i_en(en),
        .i_x(r3_d), .i_tag(r3_f), .o_lg(w_lg_d), .o_tag(w_lf)
    );

    ldrl_log2 #(.DW(DW), .TAG_W(1)) u_log_q (
        .i_clk, .i_rst_n, .i_en(en),
        .i_x(r3_q), .i_tag(r3_f.v), .o_lg(w_lg_q), .o_tag(w_lqv)
    );

    ldrl_log2 #(.DW(DW), .TAG_W(1)) u_log_m (
        .i_clk, .i_rst_n, .i_en(en),
        .i_x(r3_mx), .i_tag(r3_f.v), .o_lg(w_lg_m), .o_tag(w_lmv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_f.v <= 1'b0;
            r5_f.v <= 1'b0;
        end else if (en) begin
            r4_f.v <= w_lf.v && w_lqv && w_lmv;
            r5_f.v <= r4_f.v;
        end
        if (en) begin
            r4_f.fault  <= w_lf.fault;
            r4_f.d_zero <= w_lf.d_zero;
            r4_f.d_gt   <= w_lf.d_gt;
            r4_f.q_zero <= w_lf.q_zero;
            r4_f.q_gt   <= w_lf.q_gt;
            r4_f.den_ok <= 1'b0;
            r4_nd       <= $signed(NW'(w_lg_d)) - BASE;
            r4_nq       <= $signed(NW'(w_lg_q)) - BASE;
            r4_den      <= $signed(NW'(w_lg_m)) - BASE;

            r5_f.fault  <= r4_f.fault;
            r5_f.d_zero <= r4_f.d_zero;
            r5_f.d_gt   <= r4_f.d_gt;
            r5_f.q_zero <= r4_f.q_zero;
            r5_f.q_gt   <= r4_f.q_gt;
            r5_f.den_ok <= r4_den > '0;
            r5_td       <= AW'(r_top) * AW'(r4_den);
            r5_sd       <= AW'(r_span) * AW'(r4_nd);
            r5_sq       <= AW'(r_span) * AW'(r4_nq);
            r5_den      <= r4_den;
        end
    end

    assign w_ad = r5_td - r5_sd;
    assign w_aq = r5_td - r5_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_tag.f.v <= 1'b0;
        end else if (en) begin
            r6_tag.f.v <= r5_f.v;
        end
        if (en) begin
            r6_tag.f.fault  <= r5_f.fault;
            r6_tag.f.d_zero <= r5_f.d_zero;
            r6_tag.f.d_gt   <= r5_f.d_gt;
            r6_tag.f.q_zero <= r5_f.q_zero;
            r6_tag.f.q_gt   <= r5_f.q_gt;
            r6_tag.f.den_ok <= r5_f.den_ok;
            r6_tag.negd     <= w_ad[AW-1];
            r6_tag.negq     <= w_aq[AW-1];
            r6_magd         <= w_ad[AW-1] ? MW'(-w_ad) : MW'(w_ad);
            r6_magq         <= w_aq[AW-1] ? MW'(-w_aq) : MW'(w_aq);
            r6_den          <= r5_den[DENW-1:0];
        end
    end

    ldrl_udiv #(.NUM_W(MW), .DEN_W(DENW), .TAG_W($bits(t_stag))) u_div_lvl (
        .i_clk, .i_rst_n, .i_en(en),
        .i_num(r6_magd), .i_den(r6_den), .i_tag(r6_tag),
        .o_quo(w_quod), .o_tag(w_stag)
    );

    ldrl_udiv #(.NUM_W(MW), .DEN_W(DENW), .TAG_W(1)) u_div_lqi (
        .i_clk, .i_rst_n, .i_en(en),
        .i_num(r6_magq), .i_den(r6_den), .i_tag(r6_tag.f.v),
        .o_quo(w_quoq), .o_tag(w_sqv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= w_stag.f.v && w_sqv;
        end
        if (en) begin
            r_lvl   <= f_level(w_stag.f.d_zero, w_stag.f.d_gt, w_stag.f.fault,
                               w_stag.f.den_ok, w_stag.negd, w_quod, r_top, r_span);
            r_lqi   <= f_level(w_stag.f.q_zero, w_stag.f.q_gt, w_stag.f.fault,
                               w_stag.f.den_ok, w_stag.negq, w_quoq, r_top, r_span);
            r_fault <= w_stag.f.fault;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.signal_level = r_lvl;
    assign o_out.link_quality = r_lqi;
    assign o_out.range_fault  = r_fault;

endmodule

[hdl/ldrl_udiv.sv]
module ldrl_udiv import ldrl_pkg::*; #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 7,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic [NUM_W-1:0] o_quo,
    output logic [TAG_W-1:0] o_tag
);

    localparam int NS = (NUM_W + DIV_BPS - 1) / DIV_BPS;
    localparam int PW = NS * DIV_BPS;

    logic [PW-1:0]    r_num [NS];
    logic [PW-1:0]    r_quo [NS];
    logic [DEN_W-1:0] r_rem [NS];
    logic [DEN_W-1:0] r_den [NS];
    logic [TAG_W-1:0] r_tag [NS];

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [PW-1:0]    a_num;
        logic [PW-1:0]    a_quo;
        logic [DEN_W-1:0] a_rem;
        logic [DEN_W-1:0] a_den;
        logic [TAG_W-1:0] a_tag;
        logic [PW-1:0]    n_num;
        logic [PW-1:0]    n_quo;
        logic [DEN_W-1:0] n_rem;

        if (s == 0) begin : g_in
            assign a_num = PW'(i_num);
            assign a_quo = '0;
            assign a_rem = '0;
            assign a_den = i_den;
            assign a_tag = i_tag;
        end else begin : g_mid
            assign a_num = r_num[s-1];
            assign a_quo = r_quo[s-1];
            assign a_rem = r_rem[s-1];
            assign a_den = r_den[s-1];
            assign a_tag = r_tag[s-1];
        end

        always_comb begin
            logic [DEN_W:0] t;
            n_num = a_num;
            n_quo = a_quo;
            n_rem = a_rem;
            for (int j = 0; j < DIV_BPS; j++) begin
                t     = {n_rem, n_num[PW-1]};
                n_num = n_num << 1;
                if (t >= {1'b0, a_den}) begin
                    t     = t - {1'b0, a_den};
                    n_quo = {n_quo[PW-2:0], 1'b1};
                end else begin
                    n_quo = {n_quo[PW-2:0], 1'b0};
                end
                n_rem = t[DEN_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[s] <= '0;
            end else if (i_en) begin
                r_tag[s] <= a_tag;
            end
            if (i_en) begin
                r_num[s] <= n_num;
                r_quo[s] <= n_quo;
                r_rem[s] <= n_rem;
                r_den[s] <= a_den;
            end
        end
    end

    assign o_quo = r_quo[NS-1][NUM_W-1:0];
    assign o_tag = r_tag[NS-1];

endmodule

[hdl/ldrl_log2.sv]
module ldrl_log2 import ldrl_pkg::*; #(
    parameter int DW    = 24,
    parameter int TAG_W = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [DW-1:0]                   i_x,
    input  logic [TAG_W-1:0]                i_tag,
    output logic [$clog2(DW)+LOG_FRAC-1:0]  o_lg,
    output logic [TAG_W-1:0]                o_tag
);

    localparam int KW = $clog2(DW);
    localparam int YW = MANT_FRAC + 1;
    localparam int EW = DW + MANT_FRAC;

    logic [KW-1:0]    n_a_k;
    logic [DW-1:0]    r_a_x;
    logic [KW-1:0]    r_a_k;
    logic [TAG_W-1:0] r_a_tag;
    logic [EW-1:0]    w_sh;

    logic [YW-1:0]       r_y    [LOG_FRAC+1];
    logic [KW-1:0]       r_k    [LOG_FRAC+1];
    logic [LOG_FRAC-1:0] r_frac [LOG_FRAC+1];
    logic [TAG_W-1:0]    r_tag  [LOG_FRAC+1];

    always_comb begin
        n_a_k = '0;
        for (int i = 0; i < DW; i++) begin
            if (i_x[i]) begin
                n_a_k = KW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
        end else if (i_en) begin
            r_a_tag <= i_tag;
        end
        if (i_en) begin
            r_a_x <= i_x;
            r_a_k <= n_a_k;
        end
    end

    assign w_sh = {r_a_x, {MANT_FRAC{1'b0}}} >> r_a_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else if (i_en) begin
            r_tag[0] <= r_a_tag;
        end
        if (i_en) begin
            r_y[0]    <= w_sh[YW-1:0];
            r_k[0]    <= r_a_k;
            r_frac[0] <= '0;
        end
    end

    for (genvar s = 0; s < LOG_FRAC; s++) begin : g_sq
        logic [2*YW-1:0] w_sq;
        logic [YW:0]     w_y2;

        assign w_sq = (2*YW)'(r_y[s]) * (2*YW)'(r_y[s]);
        assign w_y2 = w_sq[MANT_FRAC+YW:MANT_FRAC];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[s+1] <= '0;
            end else if (i_en) begin
                r_tag[s+1] <= r_tag[s];
            end
            if (i_en) begin
                r_y[s+1]    <= w_y2[YW] ? w_y2[YW:1] : w_y2[YW-1:0];
                r_k[s+1]    <= r_k[s];
                r_frac[s+1] <= {r_frac[s][LOG_FRAC-2:0], w_y2[YW]};
            end
        end
    end

    assign o_lg  = {r_k[LOG_FRAC], r_frac[LOG_FRAC]};
    assign o_tag = r_tag[LOG_FRAC];

endmodule

[hdl/ldrl_checker.sv]
module ldrl_checker import ldrl_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [LVL_W-1:0] i_out_level,
    input logic                    i_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_level))
        else $error("result word dropped or changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word present after reset");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input held while output register empty");

    a_ready_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |-> i_in_ready)
        else $error("input held while result word taken");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid |-> i_cfg_ready)
        else $error("config port not ready");

endmodule

bind log_distance_rssi_lqi ldrl_checker u_ldrl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_level (o_out.signal_level),
    .i_cfg_ready (i_cfg.ready)
);
